// ----- hdl/tslp_pkg.sv -----
// Tagged sensor line parser: shared types and constants.
// Used by the parser, the output buffer and the top level.
`default_nettype none

package tslp_pkg;

  localparam int CHAR_W     = 8;
  localparam int COUNT_W    = 12;
  localparam int NUM_FIELDS = 5;
  localparam int FIELD_W    = 3;
  localparam int TIME_W     = 64;
  localparam int ACCUM_W    = 16;

  localparam logic [COUNT_W-1:0] MAX_COUNT = 12'd4095;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_F = 8'h46;
  localparam logic [CHAR_W-1:0] CHAR_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9 = 8'h39;

  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    OUTCOME_PENDING = 2'd0,
    OUTCOME_OK      = 2'd1,
    OUTCOME_FAILED  = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [TIME_W-1:0]                    frame_time;
    logic [NUM_FIELDS-1:0][COUNT_W-1:0]   counts;
    logic                                 frame_ok;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/tagged_sensor_line_parser_core.sv -----
// Tagged sensor line parser top level: stream ports, parser and result buffer.
// Depends on tslp_pkg, tslp_parser and tslp_out_buf.
//
// Takes one character per cycle on the input stream while s_tready is high, and checks the line for
// tags A to E, each followed by a decimal count of at most 4095, then F.
// On the item marked tlast one result is registered in the result buffer, in its
// output register or, while the output is stalled, its skid register, and leaves on
// the output stream: tuser is the ok flag, tdata the five counts (zero on failure)
// and the timestamp of the last character. The parser update is a single registered
// step, so a new item is taken every cycle while s_tready is high; a two-entry result
// buffer keeps s_tready high until two results wait on a stalled output.
`default_nettype none

module tagged_sensor_line_parser_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [71:0]  s_tdata,   // char_byte, time_stamp
  input  wire logic         s_tlast,   // end_of_line
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata,   // thumb, index, middle, ring, pinky counts, frame_time
  output logic              m_tuser    // frame_ok
);

  logic              accept;
  logic              res_valid;
  logic              buf_full;
  tslp_pkg::result_t res;
  tslp_pkg::result_t out_res;

  assign s_tready = !buf_full;
  assign accept   = s_tvalid && s_tready;

  tslp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_byte   (s_tdata[7:0]),
    .end_of_line (s_tlast),
    .time_stamp  (s_tdata[71:8]),
    .res_valid   (res_valid),
    .res         (res)
  );

  tslp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res),
    .full      (buf_full),
    .out_valid (m_tvalid),
    .out_data  (out_res),
    .out_ready (m_tready)
  );

  assign m_tdata = {4'b0, out_res.frame_time, out_res.counts};
  assign m_tuser = out_res.frame_ok;

endmodule

`default_nettype wire

// ----- hdl/tslp_parser.sv -----
// Per-byte line parser: tag and digit-run state, captured counts.
// Produces one result per end-of-line byte. Depends on tslp_pkg.
`default_nettype none

module tslp_parser (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic [tslp_pkg::CHAR_W-1:0]   char_byte,
  input  wire logic                          end_of_line,
  input  wire logic [tslp_pkg::TIME_W-1:0]   time_stamp,
  output logic                               res_valid,
  output tslp_pkg::result_t                  res
);

  logic [tslp_pkg::FIELD_W-1:0] field_number;
  logic                         reading_digits;
  logic                         digit_seen;
  tslp_pkg::count_t             value_accum;
  logic                         value_overflow;
  tslp_pkg::outcome_t           line_outcome;
  tslp_pkg::count_t             captured_counts [tslp_pkg::NUM_FIELDS];

  logic [tslp_pkg::FIELD_W-1:0] field_step;
  logic                         reading_step;
  logic                         seen_step;
  tslp_pkg::count_t             accum_step;
  logic                         overflow_step;
  tslp_pkg::outcome_t           outcome_step;
  tslp_pkg::count_t             captured_next [tslp_pkg::NUM_FIELDS];

  logic                         is_digit;
  logic                         tag_check;
  logic [3:0]                   digit_value;
  logic [tslp_pkg::ACCUM_W-1:0] accum_scaled;

  assign is_digit     = char_byte inside {[tslp_pkg::CHAR_0:tslp_pkg::CHAR_9]};
  assign digit_value  = 4'(char_byte - tslp_pkg::CHAR_0);
  assign accum_scaled = ({4'b0, value_accum} * 16'd10) + {12'b0, digit_value};

  always_comb begin
    field_step    = field_number;
    reading_step  = reading_digits;
    seen_step     = digit_seen;
    accum_step    = value_accum;
    overflow_step = value_overflow;
    outcome_step  = line_outcome;
    captured_next = captured_counts;
    tag_check     = 1'b0;
    if (accept && line_outcome == tslp_pkg::OUTCOME_PENDING) begin
      if (reading_digits) begin
        if (is_digit) begin
          seen_step = 1'b1;
          if (accum_scaled > {4'b0, tslp_pkg::MAX_COUNT}) begin
            overflow_step = 1'b1;
          end else begin
            accum_step = accum_scaled[tslp_pkg::COUNT_W-1:0];
          end
        end else if (!digit_seen || value_overflow ||
                     field_number >= 3'(tslp_pkg::NUM_FIELDS)) begin
          outcome_step = tslp_pkg::OUTCOME_FAILED;
        end else begin
          captured_next[field_number] = value_accum;
          field_step   = field_number + 3'd1;
          reading_step = 1'b0;
          tag_check    = 1'b1;
        end
      end else begin
        tag_check = 1'b1;
      end
      if (tag_check) begin
        if (field_step >= 3'(tslp_pkg::NUM_FIELDS)) begin
          outcome_step = (char_byte == tslp_pkg::CHAR_F) ? tslp_pkg::OUTCOME_OK
                                                          : tslp_pkg::OUTCOME_FAILED;
        end else if (char_byte == 8'(tslp_pkg::CHAR_A + {5'b0, field_step})) begin
          reading_step  = 1'b1;
          seen_step     = 1'b0;
          accum_step    = '0;
          overflow_step = 1'b0;
        end else begin
          outcome_step = tslp_pkg::OUTCOME_FAILED;
        end
      end
    end
  end

  always_comb begin
    res_valid      = accept && end_of_line;
    res.frame_ok   = (outcome_step == tslp_pkg::OUTCOME_OK);
    res.frame_time = time_stamp;
    for (int i = 0; i < tslp_pkg::NUM_FIELDS; i++) begin
      res.counts[i] = res.frame_ok ? captured_next[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_line)) begin
      field_number   <= '0;
      reading_digits <= 1'b0;
      digit_seen     <= 1'b0;
      value_accum    <= '0;
      value_overflow <= 1'b0;
      line_outcome   <= tslp_pkg::OUTCOME_PENDING;
    end else begin
      field_number   <= field_step;
      reading_digits <= reading_step;
      digit_seen     <= seen_step;
      value_accum    <= accum_step;
      value_overflow <= overflow_step;
      line_outcome   <= outcome_step;
    end
  end

  always_ff @(posedge clk) begin
    captured_counts <= captured_next;
  end

endmodule

`default_nettype wire

// ----- hdl/tslp_out_buf.sv -----
// Two-entry result buffer: output register plus skid register.
// Decouples the parser from output backpressure. Depends on tslp_pkg.
`default_nettype none

module tslp_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire tslp_pkg::result_t in_data,
  output logic                   full,
  output logic                   out_valid,
  output tslp_pkg::result_t      out_data,
  input  wire logic              out_ready
);

  logic              skid_valid;
  tslp_pkg::result_t skid_data;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_data <= skid_data;
      end
    end else if (in_valid) begin
      if (out_valid && !out_ready) begin
        skid_data <= in_data;
      end else begin
        out_data <= in_data;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tslp_checker.sv -----
// Port-level checker for the tagged sensor line parser and its bind.
// Sees only the top level's ports. Depends on tagged_sensor_line_parser_core.
`default_nettype none

module tslp_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic [71:0]  s_tdata,
  input wire logic         s_tlast,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [127:0] m_tdata,
  input wire logic         m_tuser
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[59:0] == 60'd0 && m_tdata[127:124] == 4'd0)
    else $error("failed line carries nonzero counts");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result waiting");

  a_last_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast && !m_tvalid |=>
      m_tvalid && m_tdata[123:60] == $past(s_tdata[71:8]))
    else $error("result missing or timestamp wrong after last item");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");

endmodule

bind tagged_sensor_line_parser_core tslp_checker u_checker (.*);

`default_nettype wire
